FILE: rtl/assert_macros.svh
// Assertion macros shared by the support mask RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("support mask assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("support mask assertion failed");

`endif

FILE: rtl/tsm_pkg.sv
// Types and constants for the tomography support mask block.
// No dependencies; imported by every module of the block but tsm_ram.
`default_nettype none

package tsm_pkg;

    localparam int MAX_ANGLES_DEF = 128;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_INDEX_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_CONTOUR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_CIRCLE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_VALUE    = 3'd5;

    // Configuration reset values.
    localparam logic [8:0]  IMAGE_SIZE_RST = 9'd128;

    // Commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic [6:0]         view_index;
        logic signed [15:0] view_sin;
        logic signed [15:0] view_cos;
        logic signed [15:0] view_radius;
        logic [7:0]         pixel_row;
        logic [7:0]         pixel_col;
        logic [15:0]        atten_value;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        inside_contour;
        logic        map_supported;
        logic        inside_circle;
    } out_t;

    typedef struct packed {
        logic [8:0]  image_size;
        logic [7:0]  angle_count;
        logic        use_contour;
        logic        use_circle;
        logic [15:0] map_threshold;
        logic [31:0] fill_value;
    } cfg_t;

    // One classified item as it waits between the front and back parts.
    typedef struct packed {
        logic               is_query;
        logic               slot_ok;
        logic [6:0]         slot;
        logic signed [15:0] sin;
        logic signed [15:0] cos;
        logic signed [15:0] radius;
        logic signed [10:0] x2;
        logic signed [10:0] y2;
        logic               map_ok;
    } task_t;

    typedef struct packed {
        logic idle;
        logic finishing;
        logic table_write;
    } back_status_t;

endpackage

`default_nettype wire

FILE: rtl/tsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the view table of the support mask.
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tsm_front.sv
// Front part: accepts input beats, classifies them and forms queue entries.
// Depends on tsm_pkg.
`default_nettype none

module tsm_front #(
    parameter int MAX_ANGLES = tsm_pkg::MAX_ANGLES_DEF
) (
    input  wire tsm_pkg::in_t  in_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire tsm_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output tsm_pkg::task_t     q_task
);
    import tsm_pkg::*;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_task.is_query = (in_data.command == CMD_QUERY);
        // Slots past the end of the table are dropped by the back part.
        q_task.slot_ok  = (32'(in_data.view_index) < MAX_ANGLES);
        q_task.slot     = in_data.view_index;
        q_task.sin      = in_data.view_sin;
        q_task.cos      = in_data.view_cos;
        q_task.radius   = in_data.view_radius;
        // Doubled coordinates about the image centre keep N/2 exact.
        q_task.x2 = $signed({2'b00, in_data.pixel_col, 1'b0})
                  - $signed({2'b00, cfg.image_size});
        q_task.y2 = $signed({2'b00, in_data.pixel_row, 1'b0})
                  - $signed({2'b00, cfg.image_size});
        q_task.map_ok = (cfg.map_threshold == 16'd0)
                     || (in_data.atten_value >= cfg.map_threshold);
    end

endmodule

`default_nettype wire

FILE: rtl/tsm_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on tsm_pkg for the entry type.
`default_nettype none

module tsm_queue #(
    parameter int DEPTH = tsm_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tsm_pkg::task_t push_data,
    output logic                full,
    input  wire logic           pop,
    output tsm_pkg::task_t      head,
    output logic                empty
);
    import tsm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    task_t          entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tsm_back.sv
// Back part: writes the view table and scans it for each query, one view a cycle.
// Depends on tsm_pkg and tsm_ram.
`default_nettype none

module tsm_back #(
    parameter int MAX_ANGLES = tsm_pkg::MAX_ANGLES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tsm_pkg::cfg_t  cfg,
    input  wire logic           q_empty,
    input  wire tsm_pkg::task_t q_head,
    output logic                q_pop,
    output tsm_pkg::out_t       out_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output tsm_pkg::back_status_t status
);
    import tsm_pkg::*;

    localparam int AW   = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
    localparam int CNTW = $clog2(MAX_ANGLES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

    state_t             state_reg;
    state_t             state_next;
    task_t              cur_reg;
    logic [CNTW-1:0]    issue_reg;
    logic               rd_v_reg;
    logic               prod_v_reg;
    logic               fail_reg;
    logic signed [26:0] prod_c_reg;
    logic signed [26:0] prod_s_reg;
    logic signed [15:0] rad_reg;
    logic [19:0]        sq_x_reg;
    logic [19:0]        sq_y_reg;
    logic [17:0]        nn_reg;
    logic               out_valid_reg;
    out_t               out_data_reg;

    logic [CNTW-1:0]    scan_cnt;
    logic               issue;
    logic               table_we;
    logic               out_free;
    logic [47:0]        ram_wdata;
    logic [47:0]        ram_rdata;
    logic signed [15:0] rd_sin;
    logic signed [15:0] rd_cos;
    logic signed [15:0] rd_rad;
    logic signed [26:0] prod_c_next;
    logic signed [26:0] prod_s_next;
    logic signed [28:0] dot_sum;
    logic signed [17:0] dot_scaled;
    logic signed [17:0] rad_ext;
    logic               view_fail;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic signed [21:0] sq_x_full;
    logic signed [21:0] sq_y_full;
    logic               circle_ok;
    logic               contour_ok;
    out_t               result;

    // Number of views to check: zero with contour mode off, else angle_count saturated at the table depth.
    always_comb
    begin
        if (!cfg.use_contour)
        begin
            scan_cnt = '0;
        end
        else if (32'(cfg.angle_count) >= MAX_ANGLES)
        begin
            scan_cnt = CNTW'(MAX_ANGLES);
        end
        else
        begin
            scan_cnt = CNTW'(cfg.angle_count);
        end
    end

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign table_we  = q_pop && !q_head.is_query && q_head.slot_ok;
    assign issue     = (state_reg == ST_SCAN) && (issue_reg != scan_cnt);
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_wdata = {q_head.sin, q_head.cos, q_head.radius};

    tsm_ram #(
        .WIDTH (48),
        .DEPTH (MAX_ANGLES)
    ) u_view_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (AW'(q_head.slot)),
        .wdata (ram_wdata),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_sin = ram_rdata[47:32];
    assign rd_cos = ram_rdata[31:16];
    assign rd_rad = ram_rdata[15:0];

    assign prod_c_next = 27'(cur_reg.x2) * 27'(rd_cos);
    assign prod_s_next = 27'(cur_reg.y2) * 27'(rd_sin);

    // Adding 2^14 adds one half before the floor; the shift by 15 drops the
    // doubled coordinate and the Q1.14 scale together.
    always_comb
    begin
        dot_sum    = 29'(prod_c_reg) + 29'(prod_s_reg) + 29'sd16384;
        dot_scaled = $signed({dot_sum[28:15], 4'b0000});
        rad_ext    = 18'(rad_reg);
        view_fail  = (dot_scaled > rad_ext);
    end

    // Outer corner of the pixel: step away from the centre on the positive side.
    always_comb
    begin
        cx        = (cur_reg.x2 > 11'sd0) ? cur_reg.x2 + 11'sd2 : cur_reg.x2;
        cy        = (cur_reg.y2 > 11'sd0) ? cur_reg.y2 + 11'sd2 : cur_reg.y2;
        sq_x_full = 22'(cx) * 22'(cx);
        sq_y_full = 22'(cy) * 22'(cy);
    end

    always_comb
    begin
        circle_ok  = !cfg.use_circle
                  || ((21'(sq_x_reg) + 21'(sq_y_reg)) <= 21'(nn_reg));
        contour_ok = !fail_reg;
        result.pixel_value    = (contour_ok && cur_reg.map_ok && circle_ok)
                              ? cfg.fill_value : 32'd0;
        result.inside_contour = contour_ok;
        result.map_supported  = cur_reg.map_ok;
        result.inside_circle  = circle_ok;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && q_head.is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (q_pop && q_head.is_query)
            begin
                cur_reg   <= q_head;
                issue_reg <= '0;
                fail_reg  <= 1'b0;
            end
            else if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (prod_v_reg && view_fail)
            begin
                fail_reg <= 1'b1;
            end
            prod_c_reg <= prod_c_next;
            prod_s_reg <= prod_s_next;
            rad_reg    <= rd_rad;
            sq_x_reg   <= sq_x_full[19:0];
            sq_y_reg   <= sq_y_full[19:0];
            nn_reg     <= 18'(cfg.image_size) * 18'(cfg.image_size);
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data           = out_data_reg;
    assign status.idle        = (state_reg == ST_IDLE);
    assign status.finishing   = (state_reg == ST_FINISH);
    assign status.table_write = table_we;

endmodule

`default_nettype wire

FILE: rtl/tomography_support_mask_top.sv
// Top level of the tomography support mask: configuration registers and the
// front, queue and back parts. Depends on tsm_pkg, tsm_front, tsm_queue,
// tsm_back (with tsm_ram) and assert_macros.svh.
//
// Use: the input channel (in_data, in_valid, in_stall) carries one beat per
// command. A load beat writes sine, cosine and detector radius into one slot
// of the view table and yields no result. A query beat yields exactly one
// result beat on the output channel (out_data, out_valid, out_stall): the
// fill value or zero, together with the three support flags.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high. The user must make writes only while the
// block is idle; the block itself does not enforce this.
// Timing: the front part takes a beat in the cycle it arrives whenever the
// two-entry queue has room. The back part takes one queue entry at a time. A
// load is written to the table as it is taken, and the back part stays idle.
// A query scans C views, where C is the number of views checked (angle_count
// saturated at the table depth, or zero with contour mode off), in the single
// dot-product unit, which reads one view a cycle; it then drains the read and
// product registers and passes its result to the output register.
// Reset clears the configuration to its reset values and empties the queue
// and output register; the view table holds no defined value until loaded.
// While out_stall is high the finished result holds in the output register;
// the back part waits at its next result, and the front keeps taking beats
// until the queue fills, after which in_stall rises.
`default_nettype none
`include "assert_macros.svh"

module tomography_support_mask_top #(
    parameter int MAX_ANGLES = tsm_pkg::MAX_ANGLES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tsm_pkg::in_t                    in_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    output tsm_pkg::out_t                        out_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import tsm_pkg::*;

    cfg_t         cfg_reg;
    logic         q_push;
    task_t        q_task;
    logic         q_full;
    logic         q_pop;
    task_t        q_head;
    logic         q_empty;
    back_status_t back_status;

    // The register file is always ready; a write lands on the beat's edge.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_size    <= IMAGE_SIZE_RST;
            cfg_reg.angle_count   <= '0;
            cfg_reg.use_contour   <= 1'b0;
            cfg_reg.use_circle    <= 1'b0;
            cfg_reg.map_threshold <= '0;
            cfg_reg.fill_value    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_SIZE:    cfg_reg.image_size    <= cfg_data[8:0];
                CFG_ANGLE_COUNT:   cfg_reg.angle_count   <= cfg_data[7:0];
                CFG_USE_CONTOUR:   cfg_reg.use_contour   <= cfg_data[0];
                CFG_USE_CIRCLE:    cfg_reg.use_circle    <= cfg_data[0];
                CFG_MAP_THRESHOLD: cfg_reg.map_threshold <= cfg_data[15:0];
                CFG_FILL_VALUE:    cfg_reg.fill_value    <= cfg_data;
                default:
                begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // Front part: classifies each beat and works out the doubled coordinates
    // and the attenuation test so that the back part only scans.
    tsm_front #(
        .MAX_ANGLES (MAX_ANGLES)
    ) u_front (
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_task   (q_task)
    );

    // The queue keeps item order, so loads and queries meet the table in the
    // order in which they arrived.
    tsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_task),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tsm_back #(
        .MAX_ANGLES (MAX_ANGLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (back_status)
    );

    // A nonzero pixel value only ever comes with all three tests passed.
    `TSM_ASSERT_IMPLY(a_fill_needs_support, clk, rst_n, out_valid && (out_data.pixel_value != 32'd0), out_data.inside_contour && out_data.map_supported && out_data.inside_circle)
    // A failed contour or circle test needs that mode switched on.
    `TSM_ASSERT_IMPLY(a_contour_mode, clk, rst_n, out_valid && !out_data.inside_contour, cfg_reg.use_contour)
    `TSM_ASSERT_IMPLY(a_circle_mode, clk, rst_n, out_valid && !out_data.inside_circle, cfg_reg.use_circle)
    // The table is written only while no query scan is running.
    `TSM_ASSERT_IMPLY(a_write_when_idle, clk, rst_n, back_status.table_write, back_status.idle)
    // A result that is taken is gone next cycle unless a new one is finished.
    `TSM_ASSERT_NEXT(a_result_once, clk, rst_n, out_valid && !out_stall && !back_status.finishing, !out_valid)

endmodule

`default_nettype wire
